[design/binary_to_decimal_ascii_core_defines.svh]
// Assertion macros shared by the converter modules.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define B2D_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define B2D_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define B2D_ASSERT(label, clk, rst, prop, msg)
`define B2D_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

[design/b2d_pkg.sv]
package b2d_pkg;
   localparam int unsigned MaxDigits = 20;
   localparam int unsigned QueueDepth = 2;
   localparam logic [6:0] AsciiZero = 7'd48;
   localparam logic [6:0] AsciiMinus = 7'd45;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        signed_mode;
   } req_type;

   typedef struct packed {
      logic [6:0] text_char;
      logic [4:0] text_length;
      logic       is_last;
   } rsp_type;

   // Classified work item handed from front to back.
   typedef struct packed {
      logic [63:0] mag;
      logic        neg;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } back_state_type;
endpackage

[design/b2d_front.sv]
module b2d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b2d_pkg::req_type  req_data,
   output logic              job_valid,
   input  logic              job_ready,
   output b2d_pkg::job_type  job_data
);
   import b2d_pkg::*;
   `include "binary_to_decimal_ascii_core_defines.svh"

   localparam int unsigned PtrW = $clog2(QueueDepth);

   job_type             mem_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]       cnt_ff, cnt_in;
   job_type             job;
   logic                push, pop;

   always_comb begin
      job.neg = req_data.signed_mode & req_data.value_bits[63];
      job.mag = job.neg ? (~req_data.value_bits + 64'd1) : req_data.value_bits;
   end

   assign req_ready = (cnt_ff != (PtrW+1)'(QueueDepth));
   assign job_valid = (cnt_ff != '0);
   assign job_data  = mem_ff[rd_ff];
   assign push = req_valid & req_ready;
   assign pop  = job_valid & job_ready;

   always_comb begin
      wr_in  = push ? PtrW'((wr_ff + 1'b1) % QueueDepth) : wr_ff;
      rd_in  = pop  ? PtrW'((rd_ff + 1'b1) % QueueDepth) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= job;
      end
   end

   `B2D_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= (PtrW+1)'(QueueDepth), "queue overfilled")
   `B2D_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1,
      "count did not follow push")
   `B2D_ASSERT_NEXT(a_pop_only, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1,
      "count did not follow pop")
endmodule

[design/b2d_back.sv]
module b2d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  b2d_pkg::job_type  job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b2d_pkg::rsp_type  rsp_data
);
   import b2d_pkg::*;
   `include "binary_to_decimal_ascii_core_defines.svh"

   localparam int unsigned IdxW = $clog2(MaxDigits + 1);
   localparam int unsigned BitsPerStep = 4;
   localparam int unsigned Steps = 64 / BitsPerStep;
   localparam int unsigned StepW = $clog2(Steps);
   localparam int unsigned BcdW = 4 * MaxDigits;

   back_state_type      state_ff, state_in;
   logic [63:0]         bin_ff, bin_in, bin_step;
   logic [BcdW-1:0]     bcd_ff, bcd_in, bcd_step;
   logic [StepW-1:0]    step_ff, step_in;
   logic [IdxW-1:0]     ndig;
   logic [IdxW-1:0]     pos_ff, pos_in;
   logic                neg_ff, neg_in;
   logic                sign_ff, sign_in;
   logic                fire;
   logic [4:0]          tot_len;
   logic [IdxW-1:0]     rd_idx;
   logic [3:0]          dig;

   // Shift-and-add-3 conversion to packed decimal, four input bits per cycle.
   always_comb begin
      logic [BcdW-1:0] b;
      logic [63:0]     s;
      b = bcd_ff;
      s = bin_ff;
      for (int k = 0; k < BitsPerStep; k++) begin
         for (int d = 0; d < MaxDigits; d++) begin
            if (b[4*d +: 4] >= 4'd5) b[4*d +: 4] = b[4*d +: 4] + 4'd3;
         end
         b = {b[BcdW-2:0], s[63]};
         s = {s[62:0], 1'b0};
      end
      bcd_step = b;
      bin_step = s;
   end

   // The digit count is set by the most significant nonzero digit, at least one.
   always_comb begin
      ndig = IdxW'(1);
      for (int d = 1; d < MaxDigits; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) ndig = IdxW'(d + 1);
      end
   end

   assign fire    = rsp_valid & rsp_ready;
   assign tot_len = 5'(ndig) + 5'(neg_ff);
   assign rd_idx  = ndig - 1'b1 - pos_ff;
   assign dig     = bcd_ff[{rd_idx, 2'b00} +: 4];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (job_valid) state_in = ST_CONV;
         ST_CONV: if (step_ff == StepW'(Steps - 1)) state_in = ST_EMIT;
         ST_EMIT: if (fire && !sign_ff && pos_ff == ndig - 1'b1) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      step_in   = step_ff;
      pos_in    = pos_ff;
      neg_in    = neg_ff;
      sign_in   = sign_ff;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            job_ready = 1'b1;
            bin_in    = job_data.mag;
            bcd_in    = '0;
            step_in   = '0;
            neg_in    = job_data.neg;
            sign_in   = job_data.neg;
            pos_in    = '0;
         end
         ST_CONV: begin
            bin_in  = bin_step;
            bcd_in  = bcd_step;
            step_in = step_ff + 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (fire) begin
               if (sign_ff) sign_in = 1'b0;
               else pos_in = pos_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data.text_length = tot_len;
      rsp_data.text_char   = sign_ff ? AsciiMinus : AsciiZero + 7'(dig);
      rsp_data.is_last     = !sign_ff && (pos_ff == ndig - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      pos_ff  <= pos_in;
      neg_ff  <= neg_in;
      sign_ff <= sign_in;
   end

   `B2D_ASSERT(a_valid_emit, clock, reset, rsp_valid == (state_ff == ST_EMIT), "valid off state")
   `B2D_ASSERT(a_len_range, clock, reset, !rsp_valid || (tot_len >= 5'd1 && tot_len <= 5'd21),
      "length out of range")
   `B2D_ASSERT_NEXT(a_last_idle, clock, reset, fire && rsp_data.is_last, state_ff == ST_IDLE,
      "no return to idle after last beat")
endmodule

[design/binary_to_decimal_ascii_core.sv]
// Channel | Dir | Payload                                    | Handshake
// req     | in  | value_bits[63:0], signed_mode              | req_valid / req_ready
// rsp     | out | text_char[6:0], text_length[4:0], is_last  | rsp_valid / rsp_ready
// The front splits sign and magnitude combinationally and stores the job in a two-entry queue.
// The back takes a job while idle, converts it four bits at a time, then sends one
// beat per character while rsp_ready stays high, and takes no new job until the
// last character of a number is sent.
// A low rsp_ready stalls only the back; req_ready drops once the queue holds two jobs.
// Synchronous active-high reset empties the queue and idles the back unit.
module binary_to_decimal_ascii_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b2d_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b2d_pkg::rsp_type  rsp_data
);
   import b2d_pkg::*;

   logic    job_valid, job_ready;
   job_type job_data;

   b2d_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .job_valid, .job_ready, .job_data
   );

   b2d_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
